### sv/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and codes for the script token lexer: request and token
// payloads, scan modes, token kind codes and position limits.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int POS_BITS = 24;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam int BATCH_MAX = 3;

    // Token kind codes
    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_LPAREN = 5'd1;
    localparam logic [4:0] KIND_RPAREN = 5'd2;
    localparam logic [4:0] KIND_COMMA  = 5'd3;
    localparam logic [4:0] KIND_PLUS   = 5'd4;
    localparam logic [4:0] KIND_STAR   = 5'd5;
    localparam logic [4:0] KIND_SLASH  = 5'd6;
    localparam logic [4:0] KIND_LBRACE = 5'd7;
    localparam logic [4:0] KIND_RBRACE = 5'd8;
    localparam logic [4:0] KIND_ARROW  = 5'd9;
    localparam logic [4:0] KIND_MINUS  = 5'd10;
    localparam logic [4:0] KIND_STRING = 5'd11;
    localparam logic [4:0] KIND_INT    = 5'd12;
    localparam logic [4:0] KIND_FLOAT  = 5'd13;
    localparam logic [4:0] KIND_IDENT  = 5'd14;
    localparam logic [4:0] KIND_KW0    = 5'd15;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_MINUS  = 3'd1,
        MODE_STRING = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_IDENT  = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [4:0]          token_kind;
        logic [POS_BITS-1:0] token_start;
        logic [POS_BITS-1:0] token_length;
        logic                last_token;
    } t_token;

    // Tokens produced by one request, packed to the front, in emit order
    typedef struct packed {
        logic [1:0]                   cnt;
        t_token [BATCH_MAX-1:0]       tok;
    } t_batch;

endpackage

### sv/stl_scan.sv
// ----------------------------------------------------------------------------
// stl_scan
// Lexer state registers and the single-step scan logic that turns one
// request into up to three tokens.
// ----------------------------------------------------------------------------
module stl_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  stl_pkg::t_in   i_in,
    output stl_pkg::t_batch o_batch
);
    import stl_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    localparam logic [POS_BITS-1:0] KW_LEN [5] = '{
        POS_BITS'(3), POS_BITS'(8), POS_BITS'(3), POS_BITS'(4), POS_BITS'(8)
    };
    localparam logic [7:0] KW_CHAR [5][8] = '{
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", "t", "i", "o", "n"},
        '{"r", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "p", "y", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", "t", "r", "e", "f"}
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        k = KIND_EOF;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ",":     k = KIND_COMMA;
            "+":     k = KIND_PLUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    // Keywords that have character c at offset idx
    function automatic logic [4:0] kw_match(input logic [POS_BITS-1:0] idx,
                                            input logic [7:0] c);
        logic [4:0] m;
        m = '0;
        for (int k = 0; k < 5; k++) begin
            if ((idx < KW_LEN[k]) && (KW_CHAR[k][idx[2:0]] == c)) begin
                m[k] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic t_token flush_tok(input t_mode mode,
                                         input logic [POS_BITS-1:0] start,
                                         input logic [POS_BITS-1:0] len,
                                         input logic dot,
                                         input logic [4:0] kw);
        t_token t;
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < 5; k++) begin
            if (kw[k] && (len == KW_LEN[k])) begin
                kind = KIND_KW0 + 5'(k);
            end
        end
        t.token_start = start;
        t.token_length = len;
        t.last_token = 1'b0;
        unique case (mode)
            MODE_MINUS: begin
                t.token_kind = KIND_MINUS;
                t.token_length = POS_BITS'(1);
            end
            MODE_STRING: t.token_kind = KIND_STRING;
            MODE_NUMBER: t.token_kind = dot ? KIND_FLOAT : KIND_INT;
            MODE_IDENT:  t.token_kind = kind;
            default:     t.token_kind = KIND_EOF;
        endcase
        return t;
    endfunction

    t_mode               r_mode, n_mode;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_pstart, n_pstart;
    logic [POS_BITS-1:0] r_plen, n_plen;
    logic                r_dot, n_dot;
    logic [4:0]          r_kw, n_kw;

    t_token     tok_a, tok_m, tok_d;
    logic       va, vm, vd;
    logic       again;
    logic [4:0] pk;
    logic [7:0] c;

    assign c = i_in.data_byte;
    assign pk = punct_kind(c);

    always_comb begin
        n_mode = r_mode;
        n_pos = r_pos;
        n_pstart = r_pstart;
        n_plen = r_plen;
        n_dot = r_dot;
        n_kw = r_kw;
        tok_a = '0;
        tok_m = '0;
        tok_d = '0;
        va = 1'b0;
        vm = 1'b0;
        vd = 1'b0;
        again = 1'b0;

        if (i_take && i_in.byte_present) begin
            unique case (r_mode)
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        tok_a = flush_tok(r_mode, r_pstart, r_plen, r_dot, r_kw);
                        va = 1'b1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_plen = sat_inc(r_plen);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c) || (c == CH_DOT)) begin
                        n_dot = r_dot | (c == CH_DOT);
                        n_plen = sat_inc(r_plen);
                    end else begin
                        tok_a = flush_tok(r_mode, r_pstart, r_plen, r_dot, r_kw);
                        va = 1'b1;
                        again = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || (c == CH_USCORE)) begin
                        n_kw = r_kw & kw_match(r_plen, c);
                        n_plen = sat_inc(r_plen);
                    end else begin
                        tok_a = flush_tok(r_mode, r_pstart, r_plen, r_dot, r_kw);
                        va = 1'b1;
                        again = 1'b1;
                    end
                end
                MODE_MINUS: begin
                    va = 1'b1;
                    if (c == CH_GT) begin
                        tok_a.token_kind = KIND_ARROW;
                        tok_a.token_start = r_pstart;
                        tok_a.token_length = POS_BITS'(2);
                        tok_a.last_token = 1'b0;
                        n_mode = MODE_IDLE;
                    end else begin
                        tok_a = flush_tok(r_mode, r_pstart, r_plen, r_dot, r_kw);
                        again = 1'b1;
                    end
                end
                default: again = 1'b1;
            endcase

            // Byte that ends a token starts the next one
            if (again) begin
                n_mode = MODE_IDLE;
                if (pk != KIND_EOF) begin
                    tok_m.token_kind = pk;
                    tok_m.token_start = r_pos;
                    tok_m.token_length = POS_BITS'(1);
                    tok_m.last_token = 1'b0;
                    vm = 1'b1;
                end else if (c == CH_MINUS) begin
                    n_mode = MODE_MINUS;
                    n_pstart = r_pos;
                    n_plen = POS_BITS'(1);
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                    n_pstart = sat_inc(r_pos);
                    n_plen = '0;
                end else if (is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                    n_pstart = r_pos;
                    n_plen = POS_BITS'(1);
                    n_dot = 1'b0;
                end else if (is_alpha(c) || (c == CH_USCORE)) begin
                    n_mode = MODE_IDENT;
                    n_pstart = r_pos;
                    n_plen = POS_BITS'(1);
                    n_kw = kw_match('0, c);
                end
            end
            n_pos = sat_inc(r_pos);
        end

        // End of source: flush what is pending, emit eof, return to reset
        if (i_take && i_in.end_of_source) begin
            if (n_mode != MODE_IDLE) begin
                tok_m = flush_tok(n_mode, n_pstart, n_plen, n_dot, n_kw);
                vm = 1'b1;
            end
            tok_d.token_kind = KIND_EOF;
            tok_d.token_start = n_pos;
            tok_d.token_length = '0;
            tok_d.last_token = 1'b1;
            vd = 1'b1;
            n_mode = MODE_IDLE;
            n_pos = '0;
            n_pstart = '0;
            n_plen = '0;
            n_dot = 1'b0;
            n_kw = '1;
        end
    end

    // Pack valid slots to the front
    always_comb begin
        o_batch.cnt = 2'(va) + 2'(vm) + 2'(vd);
        o_batch.tok[0] = va ? tok_a : (vm ? tok_m : tok_d);
        o_batch.tok[1] = va ? (vm ? tok_m : tok_d) : tok_d;
        o_batch.tok[2] = tok_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos <= '0;
            r_pstart <= '0;
            r_plen <= '0;
            r_dot <= 1'b0;
            r_kw <= '1;
        end else begin
            r_mode <= n_mode;
            r_pos <= n_pos;
            r_pstart <= n_pstart;
            r_plen <= n_plen;
            r_dot <= n_dot;
            r_kw <= n_kw;
        end
    end

    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_in.end_of_source) |=> (r_mode == MODE_IDLE) && (r_pos == '0))
        else $error("scan state not cleared after end of source");

    a_eof_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_in.end_of_source) |-> (o_batch.cnt != 2'd0))
        else $error("end of source produced no token");

endmodule

### sv/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue
// Four-entry shift buffer for tokens; head entry drives the result port
// straight from a register.
// ----------------------------------------------------------------------------
module stl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stl_pkg::t_batch i_batch,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output stl_pkg::t_token o_token
);
    import stl_pkg::*;

    t_token     r_buf [4];
    t_token     n_buf [4];
    logic [2:0] r_cnt, n_cnt;
    logic       pop;
    logic [2:0] base;
    logic [2:0] off [4];

    assign pop = (r_cnt != 3'd0) && i_ready;
    assign base = r_cnt - {2'b00, pop};
    assign o_valid = (r_cnt != 3'd0);
    assign o_token = r_buf[0];
    // A full batch always fits when one entry or less is held
    assign o_room = (r_cnt <= 3'd1);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            off[i] = 3'(i) - base;
        end
        for (int i = 0; i < 3; i++) begin
            n_buf[i] = pop ? r_buf[i+1] : r_buf[i];
        end
        n_buf[3] = r_buf[3];
        for (int i = 0; i < 4; i++) begin
            if (i_push && (3'(i) >= base) && (off[i] < {1'b0, i_batch.cnt})) begin
                n_buf[i] = i_batch.tok[off[i][1:0]];
            end
        end
        n_cnt = base + (i_push ? {1'b0, i_batch.cnt} : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_buf[i] <= n_buf[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("token buffer overflow");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_cnt == $past(r_cnt) + {1'b0, $past(i_batch.cnt)}))
        else $error("token count lost on push");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push without room");

endmodule

### sv/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming tokenizer: one source byte per request in, tokens (kind, start,
// length, last flag) out.
// ----------------------------------------------------------------------------
//
//   Port group  Dir  Handshake                   Payload
//   request     in   i_in_valid / o_in_ready     i_in_data   (stl_pkg::t_in)
//   token       out  o_out_valid / i_out_ready   o_out_data  (stl_pkg::t_token)
//
// One request is taken per cycle while o_in_ready is high; the scan step runs in
// the cycle it is taken and its tokens (zero to three) land in a four-entry
// buffer the next edge. Tokens leave the buffer head, a register, one per cycle
// while i_out_ready is high. o_in_ready is high while the buffer holds at most
// one token, so requests that make one token or none stream at one per cycle as
// tokens leave; a multi-token request holds requests until the buffer drains.
// Reset (i_rst_n low, synchronous) clears the scan state and empties the buffer.
//
module script_token_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  stl_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output stl_pkg::t_token  o_out_data
);
    import stl_pkg::*;

    logic   take;
    logic   room;
    t_batch batch;

    // Request handshake: room depends only on registered buffer fill
    assign o_in_ready = room;
    assign take = i_in_valid && room;

    // Scan step: mode update and token build for the request being taken
    stl_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_in    (i_in_data),
        .o_batch (batch)
    );

    // Hold tokens until the consumer takes them, in emit order
    stl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_batch (batch),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_token (o_out_data)
    );

endmodule
